@@ sv/ffa_pkg.sv @@
// Shared constants and codes for the first-fit cell allocator.
// No dependencies.
package ffa_pkg;
    localparam int MEM_SIZE    = 256;
    localparam int MAX_HANDLES = 256;
    localparam int CELL_W      = $clog2(MEM_SIZE + 2);
    localparam int ADDR_W      = $clog2(MEM_SIZE);
    localparam int HND_W       = $clog2(MAX_HANDLES);
    localparam int NID_W       = $clog2(MAX_HANDLES + 1);
    localparam int BLK_W       = 2 * CELL_W;

    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_DEFRAG = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    typedef logic [CELL_W-1:0] cell_t;
endpackage

@@ sv/ffa_ram.sv @@
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ sv/first_fit_allocator_compact.sv @@
// First-fit cell allocator with compaction: control sequencer and state memories.
// Depends on ffa_pkg and ffa_ram.
//
// channel  | ports                            | handshake
// request  | func, request_value              | start && !busy
// result   | result_handle, status            | done, one cycle, no stall
// config   | limit_wdata                      | limit_we, idle only
//
// Allocate reads and checks each scanned cell, then writes each claimed cell.
// Free reads and checks the block entry, then clears each released cell.
// Defragment reads and checks each cell and an owned cell's block start, moves
// or clears cells, and ends its scan on a final read. done is registered and
// rises in the cycle after the last of these. After reset a clearing pass zeroes
// both RAMs, busy high. Results cannot be stalled; done pulses for one cycle.
module first_fit_allocator_compact
    import ffa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        func,
    input  logic [15:0]       request_value,
    input  logic              limit_we,
    input  logic [8:0]        limit_wdata,
    output logic              done,
    output logic [7:0]        result_handle,
    output logic [1:0]        status
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] A_RD   = 4'd2;
    localparam logic [3:0] A_CHK  = 4'd3;
    localparam logic [3:0] A_FILL = 4'd4;
    localparam logic [3:0] F_RD   = 4'd5;
    localparam logic [3:0] F_CHK  = 4'd6;
    localparam logic [3:0] F_CLR  = 4'd7;
    localparam logic [3:0] D_RD   = 4'd8;
    localparam logic [3:0] D_CHK  = 4'd9;
    localparam logic [3:0] D_BCHK = 4'd10;
    localparam logic [3:0] D_WR   = 4'd11;
    localparam logic [3:0] D_ZR   = 4'd12;

    localparam cell_t LIM_MAX = cell_t'(MEM_SIZE);
    localparam cell_t END_MAX = cell_t'(MEM_SIZE + 1);

    logic [3:0]       state_reg, state_next;
    logic [8:0]       limit_reg;
    logic [NID_W-1:0] nid_reg, nid_next;
    cell_t            r_reg, r_next, w_reg, w_next, c_reg, c_next;
    cell_t            e_reg, e_next, wl_reg, wl_next, sz_reg, sz_next, run_reg, run_next;
    logic [HND_W-1:0] h_reg, h_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic             done_reg, done_next;
    logic [7:0]       hout_reg, hout_next;
    logic [1:0]       st_reg, st_next;

    logic              own_we, blk_we;
    logic [ADDR_W-1:0] own_addr;
    logic [HND_W-1:0]  blk_addr;
    logic [HND_W-1:0]  own_wd, own_rd;
    logic [BLK_W-1:0]  blk_wd, blk_rd;

    cell_t lim, run_inc, bstart, bend, bend_c, len, wl_calc, zfrom, c_dec;

    ffa_ram #(.WIDTH(HND_W), .DEPTH(MEM_SIZE)) u_owner (
        .clk(clk), .we(own_we), .addr(own_addr), .wdata(own_wd), .rdata(own_rd)
    );

    ffa_ram #(.WIDTH(BLK_W), .DEPTH(MAX_HANDLES)) u_block (
        .clk(clk), .we(blk_we), .addr(blk_addr), .wdata(blk_wd), .rdata(blk_rd)
    );

    assign lim     = (cell_t'(limit_reg) > LIM_MAX) ? LIM_MAX : cell_t'(limit_reg);
    assign bstart  = blk_rd[BLK_W-1:CELL_W];
    assign bend    = blk_rd[CELL_W-1:0];
    assign bend_c  = (bend > END_MAX) ? END_MAX : bend;
    assign run_inc = run_reg + cell_t'(1);
    assign len     = bend_c - r_reg;
    assign wl_calc = w_reg + len;
    assign zfrom   = (r_reg > wl_reg) ? r_reg : wl_reg;
    assign c_dec   = c_reg - cell_t'(1);

    always_comb
    begin
        state_next = state_reg;
        nid_next   = nid_reg;
        r_next     = r_reg;
        w_next     = w_reg;
        c_next     = c_reg;
        e_next     = e_reg;
        wl_next    = wl_reg;
        sz_next    = sz_reg;
        run_next   = run_reg;
        h_next     = h_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        hout_next  = hout_reg;
        st_next    = st_reg;
        own_we     = 1'b0;
        own_addr   = c_dec[ADDR_W-1:0];
        own_wd     = '0;
        blk_we     = 1'b0;
        blk_addr   = h_reg;
        blk_wd     = '0;

        case (state_reg)
            S_CLR:
            begin
                own_we   = 1'b1;
                blk_we   = 1'b1;
                own_addr = clr_reg;
                blk_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(MEM_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    hout_next = '0;
                    st_next   = ST_OK;
                    h_next    = request_value[HND_W-1:0];
                    sz_next   = cell_t'(request_value);
                    c_next    = cell_t'(1);
                    r_next    = cell_t'(1);
                    w_next    = cell_t'(1);
                    run_next  = '0;
                    case (func)
                        FUNC_ALLOC:
                        begin
                            if (request_value == 16'd0 || request_value > 16'(lim) ||
                                nid_reg >= NID_W'(MAX_HANDLES))
                            begin
                                st_next   = ST_NOSPACE;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = A_RD;
                            end
                        end
                        FUNC_FREE:
                        begin
                            if (request_value == 16'd0 ||
                                request_value >= 16'(MAX_HANDLES))
                            begin
                                st_next   = ST_ILLEGAL;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = F_RD;
                            end
                        end
                        FUNC_DEFRAG:
                        begin
                            state_next = D_RD;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            A_RD:
            begin
                own_addr   = ADDR_W'(r_reg - cell_t'(1));
                state_next = A_CHK;
            end
            A_CHK:
            begin
                run_next = (own_rd == '0) ? run_inc : '0;
                if (own_rd == '0 && run_inc == sz_reg)
                begin
                    blk_we     = 1'b1;
                    blk_addr   = nid_reg[HND_W-1:0];
                    blk_wd     = {r_reg - sz_reg + cell_t'(1), r_reg + cell_t'(1)};
                    h_next     = nid_reg[HND_W-1:0];
                    c_next     = r_reg - sz_reg + cell_t'(1);
                    hout_next  = 8'(nid_reg);
                    nid_next   = nid_reg + 1'b1;
                    state_next = A_FILL;
                end
                else if (r_reg == lim)
                begin
                    st_next    = ST_NOSPACE;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    r_next     = r_reg + cell_t'(1);
                    state_next = A_RD;
                end
            end
            A_FILL:
            begin
                own_we = 1'b1;
                own_wd = h_reg;
                c_next = c_reg + cell_t'(1);
                if (c_reg == r_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            F_RD:
            begin
                state_next = F_CHK;
            end
            F_CHK:
            begin
                if (bstart == '0)
                begin
                    st_next    = ST_ILLEGAL;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    blk_we = 1'b1;
                    c_next = bstart;
                    e_next = bend_c;
                    if (bstart < bend_c)
                    begin
                        state_next = F_CLR;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            F_CLR:
            begin
                own_we = 1'b1;
                c_next = c_reg + cell_t'(1);
                if (c_reg + cell_t'(1) >= e_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            D_RD:
            begin
                own_addr = ADDR_W'(r_reg - cell_t'(1));
                if (r_reg > lim)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = D_CHK;
                end
            end
            D_CHK:
            begin
                h_next   = own_rd;
                blk_addr = own_rd;
                if (own_rd != '0)
                begin
                    state_next = D_BCHK;
                end
                else
                begin
                    r_next     = r_reg + cell_t'(1);
                    state_next = D_RD;
                end
            end
            D_BCHK:
            begin
                if (bstart == r_reg)
                begin
                    blk_we     = 1'b1;
                    blk_wd     = {w_reg, wl_calc};
                    e_next     = bend_c;
                    wl_next    = wl_calc;
                    c_next     = w_reg;
                    state_next = D_WR;
                end
                else
                begin
                    w_next     = r_reg + cell_t'(1);
                    r_next     = r_reg + cell_t'(1);
                    state_next = D_RD;
                end
            end
            D_WR:
            begin
                own_we = 1'b1;
                own_wd = h_reg;
                c_next = c_reg + cell_t'(1);
                if (c_reg + cell_t'(1) == wl_reg)
                begin
                    c_next = zfrom;
                    if (zfrom < e_reg)
                    begin
                        state_next = D_ZR;
                    end
                    else
                    begin
                        w_next     = wl_reg;
                        r_next     = e_reg;
                        state_next = D_RD;
                    end
                end
            end
            D_ZR:
            begin
                own_we = 1'b1;
                c_next = c_reg + cell_t'(1);
                if (c_reg + cell_t'(1) == e_reg)
                begin
                    w_next     = wl_reg;
                    r_next     = e_reg;
                    state_next = D_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            limit_reg <= 9'd256;
            nid_reg   <= NID_W'(1);
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (limit_we)
            begin
                limit_reg <= limit_wdata;
            end
            nid_reg  <= nid_next;
            clr_reg  <= clr_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        w_reg    <= w_next;
        c_reg    <= c_next;
        e_reg    <= e_next;
        wl_reg   <= wl_next;
        sz_reg   <= sz_next;
        run_reg  <= run_next;
        h_reg    <= h_next;
        hout_reg <= hout_next;
        st_reg   <= st_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign result_handle = hout_reg;
    assign status        = st_reg;

`ifndef SYNTHESIS
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start))
        else $error("result without a request");
    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result_handle != 8'd0 |-> status == ST_OK)
        else $error("handle returned with error status");
    a_nid_range: assert property (@(posedge clk) disable iff (!rst_n)
        nid_reg != '0 && nid_reg <= NID_W'(MAX_HANDLES))
        else $error("handle counter out of range");
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("request dropped");
`endif
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for first_fit_allocator_compact: directed table, then random words.
// Checks typed rows by table, the rest by a bench predictor. Depends on ffa_pkg and the RTL.
module testbench
    import ffa_pkg::*;
();

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int N_PHASE = 7;
    localparam int PHASE_WORDS = 164;

    typedef struct {
        logic [7:0] handle;
        logic [1:0] st;
    } reply_t;

    typedef struct {
        logic [1:0]  fn;
        logic [15:0] val;
        bit          typed;
        logic [7:0]  handle;
        logic [1:0]  st;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  func = '0;
    logic [15:0] request_value = '0;
    logic        limit_we = 1'b0;
    logic [8:0]  limit_wdata = '0;
    logic        done;
    logic [7:0]  result_handle;
    logic [1:0]  status;

    reply_t      reply_q[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          words_sent = 0;

    // allocator state as seen by the bench
    logic [7:0]  owner[0:MEM_SIZE+1];
    int          blk_start[0:MAX_HANDLES-1];
    int          blk_end[0:MAX_HANDLES-1];
    int          next_handle;
    logic [8:0]  limit_reg;

    row_t dir_rows[21] = '{
        '{FUNC_ALLOC,  16'd0,     1, 8'd0, ST_NOSPACE},
        '{FUNC_ALLOC,  16'd257,   1, 8'd0, ST_NOSPACE},
        '{FUNC_ALLOC,  16'hFFFF,  1, 8'd0, ST_NOSPACE},
        '{FUNC_ALLOC,  16'd1,     1, 8'd1, ST_OK},
        '{FUNC_ALLOC,  16'd255,   1, 8'd2, ST_OK},
        '{FUNC_ALLOC,  16'd1,     1, 8'd0, ST_NOSPACE},
        '{FUNC_FREE,   16'd0,     1, 8'd0, ST_ILLEGAL},
        '{FUNC_FREE,   16'd255,   1, 8'd0, ST_ILLEGAL},
        '{FUNC_FREE,   16'd256,   1, 8'd0, ST_ILLEGAL},
        '{FUNC_FREE,   16'hFFFF,  1, 8'd0, ST_ILLEGAL},
        '{FUNC_FREE,   16'd1,     1, 8'd0, ST_OK},
        '{FUNC_FREE,   16'd1,     1, 8'd0, ST_ILLEGAL},
        '{FUNC_DEFRAG, 16'hA5A5,  1, 8'd0, ST_OK},
        '{FUNC_ALLOC,  16'd1,     1, 8'd3, ST_OK},
        '{FUNC_NONE,   16'hFFFF,  1, 8'd0, ST_OK},
        '{FUNC_FREE,   16'd2,     1, 8'd0, ST_OK},
        '{FUNC_ALLOC,  16'd3,     0, 8'd0, ST_OK},
        '{FUNC_DEFRAG, 16'd0,     0, 8'd0, ST_OK},
        '{FUNC_ALLOC,  16'd256,   0, 8'd0, ST_OK},
        '{FUNC_FREE,   16'd3,     0, 8'd0, ST_OK},
        '{FUNC_FREE,   16'd4,     0, 8'd0, ST_OK}
    };

    first_fit_allocator_compact uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .request_value(request_value),
        .limit_we(limit_we), .limit_wdata(limit_wdata),
        .done(done), .result_handle(result_handle), .status(status)
    );

    always #5 clk = ~clk;

    function automatic int usable_cells();
        return (limit_reg > MEM_SIZE) ? MEM_SIZE : int'(limit_reg);
    endfunction

    function automatic void clear_allocator();
        for (int i = 0; i <= MEM_SIZE + 1; i++)
            owner[i] = '0;
        for (int i = 0; i < MAX_HANDLES; i++)
        begin
            blk_start[i] = 0;
            blk_end[i] = 0;
        end
        next_handle = 1;
        limit_reg = 9'd256;
    endfunction

    function automatic void claim_cells(input int size, output logic [7:0] h,
                                        output logic [1:0] st);
        int lim;
        int run;
        lim = usable_cells();
        run = 0;
        h = '0;
        st = ST_NOSPACE;
        if (size == 0 || size > lim || next_handle >= MAX_HANDLES)
            return;
        for (int r = 1; r <= lim; r++)
        begin
            run = (owner[r] == 0) ? run + 1 : 0;
            if (run == size)
            begin
                blk_start[next_handle] = r - size + 1;
                blk_end[next_handle] = r + 1;
                for (int c = r - size + 1; c <= r; c++)
                    owner[c] = next_handle[7:0];
                h = next_handle[7:0];
                st = ST_OK;
                next_handle++;
                return;
            end
        end
    endfunction

    function automatic logic [1:0] release_handle(input int h);
        if (h == 0 || h >= MAX_HANDLES || blk_start[h] == 0)
            return ST_ILLEGAL;
        for (int c = blk_start[h]; c < blk_end[h] && c <= MEM_SIZE; c++)
            owner[c] = '0;
        blk_start[h] = 0;
        blk_end[h] = 0;
        return ST_OK;
    endfunction

    function automatic void compact_cells();
        int lim;
        int r;
        int w;
        int o;
        int stop;
        int len;
        lim = usable_cells();
        r = 1;
        w = 1;
        while (r <= lim)
        begin
            o = int'(owner[r]);
            if (o != 0 && o < MAX_HANDLES && blk_start[o] == r)
            begin
                stop = (blk_end[o] > MEM_SIZE + 1) ? MEM_SIZE + 1 : blk_end[o];
                len = stop - r;
                for (int x = r; x < stop; x++)
                begin
                    owner[x] = '0;
                    owner[w + (x - r)] = o[7:0];
                end
                blk_start[o] = w;
                blk_end[o] = w + len;
                w += len;
                r = stop;
            end
            else
            begin
                if (o != 0)
                    w = r + 1;
                r++;
            end
        end
    endfunction

    function automatic void apply_request(input logic [1:0] f, input logic [15:0] v,
                                          output logic [7:0] h, output logic [1:0] st);
        h = '0;
        st = ST_OK;
        case (f)
            FUNC_ALLOC:  claim_cells(int'(v), h, st);
            FUNC_FREE:   st = release_handle(int'(v));
            FUNC_DEFRAG: compact_cells();
            default:     ;
        endcase
    endfunction

    task automatic send_word(input logic [1:0] f, input logic [15:0] v, input bit typed,
                             input logic [7:0] th, input logic [1:0] ts);
        logic [7:0] ph;
        logic [1:0] ps;
        if ((words_sent < 500 || words_sent >= 750) && $urandom_range(0, 99) < 7)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        func <= f;
        request_value <= v;
        do @(posedge clk); while (busy);
        apply_request(f, v, ph, ps);
        if (typed)
            reply_q.push_back('{th, ts});
        else
            reply_q.push_back('{ph, ps});
        words_sent++;
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [8:0] v);
        drain_replies();
        limit_we <= 1'b1;
        limit_wdata <= v;
        @(posedge clk);
        limit_we <= 1'b0;
        limit_reg = v;
    endtask

    task automatic random_word();
        int r;
        int h;
        int live[$];
        logic [15:0] v;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                v = 16'($urandom_range(1, 8));
            else if (r < 90)
                v = 16'($urandom_range(1, 64));
            else if (r < 97)
                v = 16'($urandom_range(0, 300));
            else
                v = 16'($urandom);
            send_word(FUNC_ALLOC, v, 0, '0, '0);
        end
        else if (r < 75)
        begin
            for (h = 1; h < MAX_HANDLES; h++)
                if (blk_start[h] != 0)
                    live.push_back(h);
            if (live.size() != 0 && $urandom_range(0, 99) < 80)
                v = 16'(live[$urandom_range(0, live.size() - 1)]);
            else if ($urandom_range(0, 1))
                v = 16'($urandom_range(0, 300));
            else
                v = 16'($urandom);
            send_word(FUNC_FREE, v, 0, '0, '0);
        end
        else if (r < 92)
            send_word(FUNC_DEFRAG, 16'($urandom), 0, '0, '0);
        else
            send_word(FUNC_NONE, 16'($urandom), 0, '0, '0);
    endtask

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && done)
        begin
            if (reply_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: handle %0d status %0d", result_handle, status);
            end
            else
            begin
                want = reply_q.pop_front();
                if (result_handle !== want.handle || status !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: handle exp %0d got %0d, status exp %0d got %0d",
                                 want.handle, result_handle, want.st, status);
                end
            end
        end
    end

    initial
    begin
        logic [8:0] limits[N_PHASE];
        limits = '{9'd1, 9'd511, 9'd0, 9'd40, 9'd256, 9'd300, 9'd12};
        clear_allocator();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        foreach (dir_rows[i])
            send_word(dir_rows[i].fn, dir_rows[i].val, dir_rows[i].typed,
                      dir_rows[i].handle, dir_rows[i].st);
        for (int p = 0; p < N_PHASE; p++)
        begin
            if (p == N_PHASE - 1)
                write_limit(9'($urandom_range(2, 255)));
            else
                write_limit(limits[p]);
            repeat (PHASE_WORDS) random_word();
        end
        write_limit(9'd256);
        repeat (20) random_word();
        drain_replies();
        repeat (2000) @(posedge clk);
        if (mismatches == 0 && reply_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/ffa_pkg.sv
sv/ffa_ram.sv
sv/first_fit_allocator_compact.sv
tb/sv/testbench.sv
